// ----- rtl/mau_pkg.sv -----
`default_nettype none
package mau_pkg;

   typedef enum logic [3:0] {
      OP_REDUCE   = 4'd0,
      OP_NEGATE   = 4'd1,
      OP_ADD      = 4'd2,
      OP_SUBTRACT = 4'd3,
      OP_MULTIPLY = 4'd4,
      OP_POWER    = 4'd5,
      OP_INVERSE  = 4'd6,
      OP_DIVIDE   = 4'd7,
      OP_EQUAL    = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NOT_INV   = 2'd1,
      ERR_ZERO_ZERO = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RED,
      S_FIXA,
      S_DISPATCH,
      S_MUL,
      S_MRET,
      S_DIV,
      S_EUC_MUL,
      S_FIN
   } state_type;

   // what happens to a finished modular product
   typedef enum logic [2:0] {
      RET_FIN,
      RET_POW_SQ,
      RET_POW_MUL,
      RET_EUC
   } ret_type;

   localparam logic [30:0] MODULUS_RESET = 31'd1000000007;
   localparam int          RAW_BITS      = 64;
   localparam int          EXP_BITS      = 63;

endpackage
`default_nettype wire

// ----- rtl/modular_arithmetic_unit.sv -----
// channel  | direction | handshake                  | payload
// req      | in        | req_tvalid / req_tready    | tdata: a, b; tuser: operation
// rsp      | out       | rsp_tvalid / rsp_tready    | tdata: result; tuser: is_equal, error
// csr      | in        | csr_wen                    | csr_wdata: modulus
//
// every item first runs a bit-serial reduction of both operands over their 64 raw bits,
// then fixup and dispatch; reduce, negate, add, subtract and compare finish there
// multiply then goes through the shift-and-add modular multiplier
// power squares for each of the 63 exponent bits and multiplies on a set bit, all in that multiplier
// inverse and divide run euclid steps, each through the restoring
// divider then the multiplier; reset is synchronous and clears control state
// one item at a time; a finished result waits in the output register, and a
// new item is taken once the unit is idle even while rsp is stalled
`default_nettype none
module modular_arithmetic_unit
   import mau_pkg::*;
#(
   parameter int MODULUS_BITS = 31
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // operand_a [63:0], operand_b [126:64], zero
   input  wire logic [3:0]   req_tuser,   // operation [3:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // result [30:0], zero
   output logic [2:0]        rsp_tuser,   // is_equal [0], error_code [2:1]
   input  wire logic         csr_wen,
   input  wire logic [30:0]  csr_wdata    // modulus
);

   localparam int W  = MODULUS_BITS;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
   localparam logic [5:0]    DIV_LAST = 6'(W - 1);
   localparam logic [5:0]    RED_LAST = 6'(RAW_BITS - 1);
   localparam logic [5:0]    POW_LAST = 6'(EXP_BITS - 1);
   localparam logic [W-1:0]  ONE      = W'(1);

   // configuration
   logic [W-1:0] mod_ff;
   logic [W-1:0] m_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET[W-1:0];
      end else if (csr_wen) begin
         mod_ff <= csr_wdata[W-1:0];
      end
   end

   // a modulus below two acts as two
   assign m_eff = (mod_ff >> 1) == '0 ? W'(2) : mod_ff;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   ret_type   ret_ff, ret_in;
   logic            neg_ff, neg_in;
   logic [63:0]     amag_ff, amag_in;
   logic [63:0]     bsh_ff, bsh_in;
   logic [62:0]     exp_ff, exp_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [5:0]      pcnt_ff, pcnt_in;
   logic [W-1:0]    arem_ff, arem_in;
   logic [W-1:0]    brem_ff, brem_in;
   logic [W-1:0]    mx_ff, mx_in;
   logic [W-1:0]    my_ff, my_in;
   logic [W-1:0]    macc_ff, macc_in;
   logic [CW-1:0]   mcnt_ff, mcnt_in;
   logic [W-1:0]    eu_rb_ff, eu_rb_in;
   logic [W-1:0]    eu_sa_ff, eu_sa_in;
   logic [W-1:0]    eu_sb_ff, eu_sb_in;
   logic [W-1:0]    dq_ff, dq_in;
   logic [W-1:0]    dsh_ff, dsh_in;
   logic [W-1:0]    drem_ff, drem_in;
   logic [W-1:0]    res_ff, res_in;
   logic            eq_ff, eq_in;
   logic [1:0]      err_ff, err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    out_res_ff, out_res_in;
   logic            out_eq_ff, out_eq_in;
   logic [1:0]      out_err_ff, out_err_in;

   // datapath slices
   logic [W:0]   ra_t, rb_t, m1_t, m2_t, d_t, sum_t, sub_t, sn_t;
   logic [W-1:0] m1_r, m2_r, sn_r;
   logic         adv;

   always_comb begin
      // reduction slices: remainder doubles and takes the next bit
      ra_t = {arem_ff, amag_ff[63]};
      if (ra_t >= {1'b0, m_eff}) ra_t = ra_t - {1'b0, m_eff};
      rb_t = {brem_ff, bsh_ff[63]};
      if (rb_t >= {1'b0, m_eff}) rb_t = rb_t - {1'b0, m_eff};
      // modular multiply step, multiplier msb first
      m1_t = {macc_ff, 1'b0};
      if (m1_t >= {1'b0, m_eff}) m1_t = m1_t - {1'b0, m_eff};
      m1_r = m1_t[W-1:0];
      m2_t = {1'b0, m1_r} + (my_ff[W-1] ? {1'b0, mx_ff} : '0);
      if (m2_t >= {1'b0, m_eff}) m2_t = m2_t - {1'b0, m_eff};
      m2_r = m2_t[W-1:0];
      // restoring divider step
      d_t = {drem_ff, dsh_ff[W-1]};
      if (d_t >= {1'b0, eu_rb_ff}) d_t = d_t - {1'b0, eu_rb_ff};
      // add and subtract of residues
      sum_t = {1'b0, arem_ff} + {1'b0, brem_ff};
      if (sum_t >= {1'b0, m_eff}) sum_t = sum_t - {1'b0, m_eff};
      sub_t = (arem_ff >= brem_ff) ? {1'b0, arem_ff} - {1'b0, brem_ff}
                                   : {1'b0, arem_ff} + {1'b0, m_eff} - {1'b0, brem_ff};
      // euclid coefficient update, kept as a residue
      sn_t = (eu_sa_ff >= macc_ff) ? {1'b0, eu_sa_ff} - {1'b0, macc_ff}
                                   : {1'b0, eu_sa_ff} + {1'b0, m_eff} - {1'b0, macc_ff};
      sn_r = sn_t[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ret_ff     <= ret_in;
      neg_ff     <= neg_in;
      amag_ff    <= amag_in;
      bsh_ff     <= bsh_in;
      exp_ff     <= exp_in;
      cnt_ff     <= cnt_in;
      pcnt_ff    <= pcnt_in;
      arem_ff    <= arem_in;
      brem_ff    <= brem_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      macc_ff    <= macc_in;
      mcnt_ff    <= mcnt_in;
      eu_rb_ff   <= eu_rb_in;
      eu_sa_ff   <= eu_sa_in;
      eu_sb_ff   <= eu_sb_in;
      dq_ff      <= dq_in;
      dsh_ff     <= dsh_in;
      drem_ff    <= drem_in;
      res_ff     <= res_in;
      eq_ff      <= eq_in;
      err_ff     <= err_in;
      out_res_ff <= out_res_in;
      out_eq_ff  <= out_eq_in;
      out_err_ff <= out_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ret_in       = ret_ff;
      neg_in       = neg_ff;
      amag_in      = amag_ff;
      bsh_in       = bsh_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      pcnt_in      = pcnt_ff;
      arem_in      = arem_ff;
      brem_in      = brem_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      macc_in      = macc_ff;
      mcnt_in      = mcnt_ff;
      eu_rb_in     = eu_rb_ff;
      eu_sa_in     = eu_sa_ff;
      eu_sb_in     = eu_sb_ff;
      dq_in        = dq_ff;
      dsh_in       = dsh_ff;
      drem_in      = drem_ff;
      res_in       = res_ff;
      eq_in        = eq_ff;
      err_in       = err_ff;
      out_res_in   = out_res_ff;
      out_eq_in    = out_eq_ff;
      out_err_in   = out_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      adv          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = op_type'(req_tuser[3:0]);
               neg_in  = req_tdata[63];
               amag_in = req_tdata[63] ? 64'd0 - req_tdata[63:0] : req_tdata[63:0];
               bsh_in  = {1'b0, req_tdata[126:64]};
               exp_in  = req_tdata[126:64];
               arem_in = '0;
               brem_in = '0;
               cnt_in  = '0;
               res_in  = '0;
               eq_in   = 1'b0;
               err_in  = ERR_NONE;
               state_in = S_RED;
            end
         end
         S_RED: begin
            arem_in = ra_t[W-1:0];
            brem_in = rb_t[W-1:0];
            amag_in = {amag_ff[62:0], 1'b0};
            bsh_in  = {bsh_ff[62:0], 1'b0};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == RED_LAST) state_in = S_FIXA;
         end
         S_FIXA: begin
            // negative raw value: residue is modulus minus remainder
            if (neg_ff && arem_ff != '0) arem_in = m_eff - arem_ff;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_FIN;
            case (op_ff)
               OP_REDUCE:   res_in = arem_ff;
               OP_NEGATE:   res_in = (arem_ff != '0) ? m_eff - arem_ff : '0;
               OP_ADD:      res_in = sum_t[W-1:0];
               OP_SUBTRACT: res_in = sub_t[W-1:0];
               OP_EQUAL:    eq_in  = (arem_ff == brem_ff);
               OP_MULTIPLY: begin
                  mx_in = arem_ff; my_in = brem_ff; macc_in = '0; mcnt_in = '0;
                  ret_in = RET_FIN; state_in = S_MUL;
               end
               OP_POWER: begin
                  if (arem_ff == '0 && exp_ff == '0) begin
                     res_in = ONE;
                     err_in = ERR_ZERO_ZERO;
                  end else begin
                     // left to right: square, then multiply on a set bit
                     pcnt_in = '0;
                     mx_in = ONE; my_in = ONE; macc_in = '0; mcnt_in = '0;
                     ret_in = RET_POW_SQ; state_in = S_MUL;
                  end
               end
               OP_INVERSE, OP_DIVIDE: begin
                  eu_rb_in = m_eff;
                  eu_sa_in = ONE;
                  eu_sb_in = '0;
                  dsh_in   = (op_ff == OP_INVERSE) ? arem_ff : brem_ff;
                  drem_in  = '0; dq_in = '0; cnt_in = '0;
                  state_in = S_DIV;
               end
               default: ;
            endcase
         end
         S_MUL: begin
            macc_in = m2_r;
            my_in   = {my_ff[W-2:0], 1'b0};
            mcnt_in = mcnt_ff + CW'(1);
            if (mcnt_ff == MUL_LAST) state_in = S_MRET;
         end
         S_MRET: begin
            case (ret_ff)
               RET_FIN: begin
                  res_in = macc_ff; state_in = S_FIN;
               end
               RET_POW_SQ: begin
                  if (exp_ff[62]) begin
                     mx_in = macc_ff; my_in = arem_ff; macc_in = '0; mcnt_in = '0;
                     ret_in = RET_POW_MUL; state_in = S_MUL;
                  end else begin
                     adv = 1'b1;
                  end
               end
               RET_POW_MUL: begin
                  adv = 1'b1;
               end
               RET_EUC: begin
                  eu_sa_in = eu_sb_ff;
                  eu_rb_in = drem_ff;
                  eu_sb_in = sn_r;
                  if (drem_ff == '0) begin
                     // gcd is the last nonzero remainder
                     if (eu_rb_ff != ONE) begin
                        res_in = '0; err_in = ERR_NOT_INV; state_in = S_FIN;
                     end else if (op_ff == OP_INVERSE) begin
                        res_in = eu_sb_ff; state_in = S_FIN;
                     end else begin
                        mx_in = arem_ff; my_in = eu_sb_ff; macc_in = '0; mcnt_in = '0;
                        ret_in = RET_FIN; state_in = S_MUL;
                     end
                  end else begin
                     dsh_in = eu_rb_ff; drem_in = '0; dq_in = '0; cnt_in = '0;
                     state_in = S_DIV;
                  end
               end
               default: state_in = S_FIN;
            endcase
            if (adv) begin
               if (pcnt_ff == POW_LAST) begin
                  res_in = macc_ff; state_in = S_FIN;
               end else begin
                  exp_in  = {exp_ff[61:0], 1'b0};
                  pcnt_in = pcnt_ff + 6'd1;
                  mx_in = macc_ff; my_in = macc_ff; macc_in = '0; mcnt_in = '0;
                  ret_in = RET_POW_SQ; state_in = S_MUL;
               end
            end
         end
         S_DIV: begin
            drem_in = d_t[W-1:0];
            dq_in   = {dq_ff[W-2:0], ({drem_ff, dsh_ff[W-1]} >= {1'b0, eu_rb_ff})};
            dsh_in  = {dsh_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) state_in = S_EUC_MUL;
         end
         S_EUC_MUL: begin
            // q * sb for the coefficient update
            mx_in = eu_sb_ff; my_in = dq_ff; macc_in = '0; mcnt_in = '0;
            ret_in = RET_EUC; state_in = S_MUL;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_res_in   = res_ff;
               out_eq_in    = eq_ff;
               out_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - W){1'b0}}, out_res_ff};
   assign rsp_tuser  = {out_err_ff, out_eq_ff};

   // residues stay below the modulus inside the multiplier
   a_macc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> macc_ff < m_eff)
      else $error("multiplier accumulator out of range");

   // a compare never reports an error
   a_eq_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_eq_ff |-> out_err_ff == ERR_NONE)
      else $error("equal flag with error");

   // zero to the zero always answers one
   a_zz_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_err_ff == ERR_ZERO_ZERO |-> out_res_ff == ONE)
      else $error("zero to zero result not one");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import mau_pkg::*;

   localparam int          MOD_BITS        = 31;
   localparam logic [3:0]  OP_FIRST_UNUSED = 4'd9;
   localparam logic [63:0] INT64_MAX       = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] INT64_MIN       = 64'h8000_0000_0000_0000;
   localparam logic [62:0] EXP_MAX         = {63{1'b1}};
   localparam int          RANDOM_ITEMS    = 1000;
   localparam int          MAX_REPORTS     = 10;

   // one request item plus an optional hand-typed answer
   typedef struct {
      logic [3:0]  op;
      logic [63:0] a;
      logic [62:0] b;
      bit          known;
      logic [30:0] res;
      logic        eq;
      err_type     err;
   } req_item_type;

   typedef struct {
      logic [30:0] res;
      logic        eq;
      err_type     err;
   } answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // operand_a [63:0], operand_b [126:64], zero
   logic [3:0]   req_tuser = '0;   // operation [3:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;        // result [30:0], zero
   logic [2:0]   rsp_tuser;        // is_equal [0], error_code [2:1]
   logic         csr_wen = 1'b0;
   logic [30:0]  csr_wdata = '0;   // modulus

   // testbench copy of the modulus register
   logic [30:0]  mod_reg = MODULUS_RESET;
   req_item_type on_bus;
   req_item_type directed_rows[$];
   answer_type   pending_answers[$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           sent_items = 0;
   int           mismatches = 0;

   modular_arithmetic_unit #(.MODULUS_BITS(MOD_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // a register value below 2 behaves as modulus 2
   function automatic logic [63:0] ring_size();
      return (mod_reg < 31'd2) ? 64'd2 : {33'd0, mod_reg};
   endfunction

   // residue of a two's complement value
   function automatic logic [63:0] signed_residue(logic [63:0] raw, logic [63:0] m);
      logic [63:0] mag;
      logic [63:0] r;
      if (raw[63]) begin
         mag = 64'd0 - raw;
         r   = mag % m;
         return (r != 0) ? m - r : 64'd0;
      end
      return raw % m;
   endfunction

   // operands stay below 2^31 so the product fits in 64 bits
   function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (x * y) % m;
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] base, logic [62:0] ex,
                                           logic [63:0] m);
      logic [63:0] acc;
      logic [62:0] e;
      acc = 64'd1 % m;
      e   = ex;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base, m);
         e    = e >> 1;
         base = mod_mul(base, base, m);
      end
      return acc;
   endfunction

   // extended euclid; returns 0 when x shares a factor with m
   function automatic bit mod_inverse(logic [63:0] x, logic [63:0] m, output logic [63:0] inv);
      longint ra, sa, rb, sb, q, rn, sn;
      ra = x;  sa = 1;
      rb = m;  sb = 0;
      while (rb > 0) begin
         q  = ra / rb;
         rn = ra % rb;
         sn = sa - q * sb;
         ra = rb;  sa = sb;
         rb = rn;  sb = sn;
      end
      if (ra != 1) begin
         inv = 64'd0;
         return 1'b0;
      end
      inv = signed_residue(sa, m);
      return 1'b1;
   endfunction

   function automatic answer_type compute_answer(req_item_type it);
      answer_type  ans;
      logic [63:0] m, ra, rb, r, t;
      m  = ring_size();
      ra = signed_residue(it.a, m);
      rb = {1'b0, it.b} % m;
      r  = 64'd0;
      ans.eq  = 1'b0;
      ans.err = ERR_NONE;
      case (it.op)
         OP_REDUCE:   r = ra;
         OP_NEGATE:   r = (ra != 0) ? m - ra : 64'd0;
         OP_ADD:      r = (ra + rb) % m;
         OP_SUBTRACT: r = (ra + m - rb) % m;
         OP_MULTIPLY: r = mod_mul(ra, rb, m);
         OP_POWER: begin
            if (ra == 0 && it.b == 0) begin
               r       = 64'd1;
               ans.err = ERR_ZERO_ZERO;
            end else begin
               r = mod_pow(ra, it.b, m);
            end
         end
         OP_INVERSE: begin
            if (!mod_inverse(ra, m, r)) ans.err = ERR_NOT_INV;
         end
         OP_DIVIDE: begin
            if (mod_inverse(rb, m, t)) r = mod_mul(ra, t, m);
            else ans.err = ERR_NOT_INV;
         end
         OP_EQUAL:    ans.eq = (ra == rb);
         default:     ;
      endcase
      ans.res = r[30:0];
      return ans;
   endfunction

   // ---------------------------------------------------------------- checking

   // sampled at the rising edge, before the block updates its registers
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (on_bus.known) begin
               want.res = on_bus.res;
               want.eq  = on_bus.eq;
               want.err = on_bus.err;
            end else begin
               want = compute_answer(on_bus);
            end
            pending_answers.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result item: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata[30:0] !== want.res || rsp_tuser[0] !== want.eq ||
                   rsp_tuser[2:1] !== want.err || rsp_tdata[31] !== 1'b0) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result mismatch: expected res %0d eq %0d err %0d, got %0d %0d %0d",
                              want.res, want.eq, want.err,
                              rsp_tdata[30:0], rsp_tuser[0], rsp_tuser[2:1]);
               end
            end
         end
      end
   end

   // receiver stalls at random
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // ---------------------------------------------------------------- stimulus

   task automatic add_row(logic [3:0] op, logic [63:0] a, logic [62:0] b, bit known,
                          logic [30:0] res, logic eq, err_type err);
      req_item_type it;
      it.op = op;  it.a = a;  it.b = b;
      it.known = known;  it.res = res;  it.eq = eq;  it.err = err;
      directed_rows.push_back(it);
   endtask

   // idle mix follows how far the run has come
   task automatic pick_idle_mix();
      if (sent_items < 350) begin
         send_idle_pct = 29;  recv_idle_pct = 86;
      end else if (sent_items < 700) begin
         send_idle_pct = 86;  recv_idle_pct = 29;
      end else begin
         send_idle_pct = 0;   recv_idle_pct = 0;
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(req_item_type it);
      pick_idle_mix();
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      on_bus     = it;
      req_tdata  = {1'b0, it.b, it.a};
      req_tuser  = it.op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_all_answered();
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_modulus(logic [30:0] value);
      csr_wen   = 1'b1;
      csr_wdata = value;
      mod_reg   = value;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // first operand: small, negative, wide, or close to a multiple of the modulus
   function automatic logic [63:0] rand_operand_a();
      logic [63:0] m;
      m = ring_size();
      case ($urandom_range(7))
         0:       return 64'($urandom_range(1000));
         1:       return 64'd0 - $urandom_range(1000);
         2:       return m * $urandom + $urandom_range(3);
         3:       return 64'd0 - (m * $urandom);
         4:       return ($urandom_range(1)) ? INT64_MAX - $urandom_range(3)
                                             : INT64_MIN + $urandom_range(3);
         5:       return m - $urandom_range(2);
         default: return rand64();
      endcase
   endfunction

   function automatic logic [62:0] rand_operand_b(logic [3:0] op);
      logic [63:0] m;
      logic [63:0] w;
      m = ring_size();
      if (op == OP_POWER) begin
         // mostly short exponents, now and then full width
         case ($urandom_range(19))
            0:       return EXP_MAX - $urandom_range(3);
            1:       return 63'(rand64());
            2:       return 63'd0;
            default: begin
               w = rand64();
               return w[62:0] >> (63 - $urandom_range(1, 20));
            end
         endcase
      end
      case ($urandom_range(5))
         0:       return 63'($urandom_range(1000));
         1:       return 63'(m * $urandom);
         2:       return 63'(m - $urandom_range(2));
         3:       return EXP_MAX - $urandom_range(3);
         default: return 63'(rand64());
      endcase
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      if ($urandom_range(19) == 0) it.op = 4'($urandom_range(OP_FIRST_UNUSED, 15));
      else it.op = 4'($urandom_range(OP_REDUCE, OP_EQUAL));
      it.a     = rand_operand_a();
      it.b     = rand_operand_b(it.op);
      it.known = 1'b0;
      it.res   = '0;
      it.eq    = 1'b0;
      it.err   = ERR_NONE;
      return it;
   endfunction

   initial begin
      logic [30:0] m;
      logic [30:0] moduli[$];
      int          per_phase;
      m = MODULUS_RESET;

      // directed rows at the reset modulus
      add_row(OP_REDUCE,   64'd0,           63'd0,       1, 31'd0,   0, ERR_NONE);
      add_row(OP_REDUCE,   64'hffff_ffff_ffff_ffff, 63'd0, 1, m - 31'd1, 0, ERR_NONE);
      add_row(OP_REDUCE,   INT64_MAX,       EXP_MAX,     0, 31'd0,   0, ERR_NONE);
      add_row(OP_REDUCE,   INT64_MIN,       63'd0,       0, 31'd0,   0, ERR_NONE);
      add_row(OP_NEGATE,   64'd0,           63'd5,       1, 31'd0,   0, ERR_NONE);
      add_row(OP_NEGATE,   64'd1,           63'd0,       1, m - 31'd1, 0, ERR_NONE);
      add_row(OP_ADD,      {33'd0, m - 31'd1}, 63'd1,    1, 31'd0,   0, ERR_NONE);
      add_row(OP_SUBTRACT, 64'd0,           63'd1,       1, m - 31'd1, 0, ERR_NONE);
      add_row(OP_MULTIPLY, 64'hffff_ffff_ffff_ffff, {32'd0, m - 31'd1}, 1, 31'd1, 0, ERR_NONE);
      add_row(OP_MULTIPLY, INT64_MAX,       EXP_MAX,     0, 31'd0,   0, ERR_NONE);
      // zero to the zero, both plain zero and a multiple of the modulus
      add_row(OP_POWER,    64'd0,           63'd0,       1, 31'd1,   0, ERR_ZERO_ZERO);
      add_row(OP_POWER,    {33'd0, m},      63'd0,       1, 31'd1,   0, ERR_ZERO_ZERO);
      add_row(OP_POWER,    64'd5,           63'd0,       1, 31'd1,   0, ERR_NONE);
      add_row(OP_POWER,    64'd0,           63'd5,       1, 31'd0,   0, ERR_NONE);
      add_row(OP_POWER,    64'd2,           EXP_MAX,     0, 31'd0,   0, ERR_NONE);
      add_row(OP_POWER,    64'hffff_ffff_ffff_fffe, {32'd0, m - 31'd2}, 0, 31'd0, 0, ERR_NONE);
      // inverse and divide, invertible or not
      add_row(OP_INVERSE,  64'd0,           63'd0,       1, 31'd0,   0, ERR_NOT_INV);
      add_row(OP_INVERSE,  {33'd0, m},      63'd0,       1, 31'd0,   0, ERR_NOT_INV);
      add_row(OP_INVERSE,  64'd1,           63'd0,       1, 31'd1,   0, ERR_NONE);
      add_row(OP_INVERSE,  64'hffff_ffff_ffff_ffff, 63'd0, 1, m - 31'd1, 0, ERR_NONE);
      add_row(OP_DIVIDE,   64'd7,           63'd0,       1, 31'd0,   0, ERR_NOT_INV);
      add_row(OP_DIVIDE,   64'd6,           63'd3,       1, 31'd2,   0, ERR_NONE);
      add_row(OP_EQUAL,    64'hffff_ffff_ffff_ffff, {32'd0, m - 31'd1}, 1, 31'd0, 1, ERR_NONE);
      add_row(OP_EQUAL,    64'd0,           63'd1,       1, 31'd0,   0, ERR_NONE);
      // unused operation codes answer all zeros
      add_row(OP_FIRST_UNUSED, INT64_MAX,   EXP_MAX,     1, 31'd0,   0, ERR_NONE);
      add_row(4'd15,       INT64_MIN,       EXP_MAX,     1, 31'd0,   0, ERR_NONE);

      // moduli to sweep: extremes, below-two values, composites, random
      moduli = '{31'h7fff_ffff, 31'd2, 31'd0, 31'd1, 31'd97, 31'd12,
                 31'h7fff_fffe, 31'd65536, 31'd1000000007, 31'd3};
      moduli.push_back(31'($urandom));
      per_phase = RANDOM_ITEMS / (moduli.size() + 1);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      repeat (per_phase) send_item(rand_item());

      foreach (moduli[k]) begin
         wait_all_answered();
         write_modulus(moduli[k]);
         repeat (per_phase) send_item(rand_item());
      end
      wait_all_answered();
      repeat (100) @(posedge clock);

      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog: worst case every item a full-width power behind long stalls
   initial begin
      #400_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/mau_pkg.sv
rtl/modular_arithmetic_unit.sv
sim/testbench.sv
